// ----- hw/rtl/ethernet_ip_header_classifier_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Ethernet/IP header classifier
// Concurrent assertion helpers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ETHERNET_IP_HEADER_CLASSIFIER_CORE_ASSERT_SVH
`define ETHERNET_IP_HEADER_CLASSIFIER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define EHC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ehc assertion failed");
`define EHC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("ehc forbidden condition seen");
`else
`define EHC_ASSERT(lbl, clk, rst_n, prop)
`define EHC_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ----- hw/rtl/ehc_pkg.sv -----
// ----------------------------------------------------------------------------
// Ethernet/IP header classifier package
// Transaction types, record type and protocol constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ehc_pkg;

  localparam logic [15:0] TYPE_ARP  = 16'h0806;
  localparam logic [15:0] TYPE_IPV4 = 16'h0800;

  localparam logic [7:0] IP_PROTO_ICMP = 8'd1;
  localparam logic [7:0] IP_PROTO_TCP  = 8'd6;
  localparam logic [7:0] IP_PROTO_UDP  = 8'd17;

  localparam logic [15:0] ETH_HDR_LEN   = 16'd14;
  localparam logic [15:0] ARP_MIN_LEN   = 16'd42;
  localparam logic [15:0] IPV4_MIN_LEN  = 16'd34;
  localparam logic [6:0]  ICMP_HDR_LEN  = 7'd8;
  localparam logic [6:0]  TCP_HDR_BYTES = 7'd20;
  localparam logic [6:0]  UDP_HDR_LEN   = 7'd8;

  localparam logic [2:0] CLS_OTHER = 3'd0;
  localparam logic [2:0] CLS_ARP   = 3'd1;
  localparam logic [2:0] CLS_IPV4  = 3'd2;
  localparam logic [2:0] CLS_ICMP  = 3'd3;
  localparam logic [2:0] CLS_TCP   = 3'd4;
  localparam logic [2:0] CLS_UDP   = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } ehc_in_t;

  typedef struct packed {
    logic [2:0]  protocol_class;
    logic [15:0] type_field;
    logic [31:0] source_address;
    logic [31:0] target_address;
    logic [7:0]  ip_proto;
    logic [7:0]  time_to_live;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  tcp_flag_bits;
    logic [15:0] op_or_type_code;
    logic [15:0] frame_length;
    logic [31:0] packet_number;
  } ehc_out_t;

  typedef struct packed {
    logic [2:0]  cls;
    logic [15:0] type_field;
    logic [15:0] proto_ttl;
    logic [15:0] arp_op;
    logic [31:0] ip_src;
    logic [31:0] ip_dst;
    logic [31:0] arp_src;
    logic [31:0] arp_dst;
    logic [31:0] l4_head;
    logic [7:0]  l4_flags;
    logic [15:0] frame_len;
    logic [31:0] pkt_num;
  } ehc_rec_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ethernet_ip_header_classifier_core.sv -----
// A frame's result record is formed and queued when its last byte is accepted.
// Throughput: one frame byte per cycle; the input stalls only while the record queue is full.
// One result per frame of 14 bytes or more while capture is on, passed through the record queue and output register.
// Reset: synchronous active-low rst_n clears all capture state, the packet count and the queue.
// After reset capture is enabled and no result transaction is pending.
// ----------------------------------------------------------------------------
// Ethernet/IP header classifier core
// Streams frame bytes, extracts header fields and emits one record per frame of 14 bytes or more while capture is on.
// ----------------------------------------------------------------------------
`default_nettype none

module ethernet_ip_header_classifier_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic             cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire ehc_pkg::ehc_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output ehc_pkg::ehc_out_t     out_data
);

  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_empty;
  ehc_pkg::ehc_rec_t q_wr_rec;
  ehc_pkg::ehc_rec_t q_rd_rec;

  ehc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_rec     (q_wr_rec)
  );

  ehc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_rec (q_wr_rec),
    .full   (q_full),
    .pop    (q_pop),
    .rd_rec (q_rd_rec),
    .empty  (q_empty)
  );

  ehc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rec     (q_rd_rec),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/ehc_front.sv -----
// ----------------------------------------------------------------------------
// Header classifier front end
// Captures header bytes by offset and classifies the frame on its last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ehc_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic             cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire ehc_pkg::ehc_in_t in_data,
  input  wire logic             q_full,
  output logic                  q_push,
  output ehc_pkg::ehc_rec_t     q_rec
);

  logic        en_r;
  logic [15:0] idx_r;
  logic [31:0] pkt_r;
  logic [15:0] type_r,  type_nxt;
  logic [3:0]  hlw_r,   hlw_nxt;
  logic [15:0] pt_r,    pt_nxt;
  logic [15:0] aop_r,   aop_nxt;
  logic [31:0] isrc_r,  isrc_nxt;
  logic [31:0] idst_r,  idst_nxt;
  logic [31:0] asrc_r,  asrc_nxt;
  logic [31:0] adst_r,  adst_nxt;
  logic [31:0] l4h_r,   l4h_nxt;
  logic [7:0]  l4f_r,   l4f_nxt;

  logic        acc;
  logic [7:0]  b;
  logic [15:0] pos;
  logic [15:0] len;
  logic [3:0]  ihl;
  logic [6:0]  t0;
  logic [15:0] t;
  logic [6:0]  thr;
  logic [16:0] len_x;
  logic [2:0]  cls;

  assign in_stall = q_full;
  assign acc      = in_valid && !in_stall;
  assign b        = in_data.data_byte;
  assign pos      = idx_r;
  assign len      = (pos == 16'hFFFF) ? 16'hFFFF : pos + 16'd1;

  always_comb begin
    type_nxt = type_r;
    hlw_nxt  = hlw_r;
    pt_nxt   = pt_r;
    aop_nxt  = aop_r;
    isrc_nxt = isrc_r;
    idst_nxt = idst_r;
    asrc_nxt = asrc_r;
    adst_nxt = adst_r;
    l4h_nxt  = l4h_r;
    l4f_nxt  = l4f_r;
    if (pos == 16'd12 || pos == 16'd13) begin
      type_nxt = {type_r[7:0], b};
    end
    if (pos == 16'd14) begin
      hlw_nxt = b[3:0];
    end
    if (pos == 16'd22) begin
      pt_nxt[7:0] = b;
    end
    if (pos == 16'd23) begin
      pt_nxt[15:8] = b;
    end
    if (pos >= 16'd26 && pos <= 16'd29) begin
      isrc_nxt = {isrc_r[23:0], b};
    end
    if (pos >= 16'd30 && pos <= 16'd33) begin
      idst_nxt = {idst_r[23:0], b};
    end
    if (pos == 16'd20 || pos == 16'd21) begin
      aop_nxt = {aop_r[7:0], b};
    end
    if (pos >= 16'd28 && pos <= 16'd31) begin
      asrc_nxt = {asrc_r[23:0], b};
    end
    if (pos >= 16'd38 && pos <= 16'd41) begin
      adst_nxt = {adst_r[23:0], b};
    end
    ihl = (pos == 16'd14) ? b[3:0] : hlw_r;
    t0  = 7'(ehc_pkg::ETH_HDR_LEN) + {1'b0, ihl, 2'b00};
    t   = pos - {9'd0, t0};
    if (pos >= {9'd0, t0}) begin
      if (t <= 16'd3) begin
        l4h_nxt = {l4h_r[23:0], b};
      end
      if (t == 16'd13) begin
        l4f_nxt = b;
      end
    end
  end

  always_comb begin
    thr   = 7'(ehc_pkg::ETH_HDR_LEN) + {1'b0, hlw_nxt, 2'b00};
    len_x = {1'b0, len};
    cls   = ehc_pkg::CLS_OTHER;
    if (type_nxt == ehc_pkg::TYPE_ARP && len >= ehc_pkg::ARP_MIN_LEN) begin
      cls = ehc_pkg::CLS_ARP;
    end else if (type_nxt == ehc_pkg::TYPE_IPV4 && len >= ehc_pkg::IPV4_MIN_LEN) begin
      cls = ehc_pkg::CLS_IPV4;
      if (pt_nxt[15:8] == ehc_pkg::IP_PROTO_ICMP &&
          len_x >= 17'(thr) + 17'(ehc_pkg::ICMP_HDR_LEN)) begin
        cls = ehc_pkg::CLS_ICMP;
      end else if (pt_nxt[15:8] == ehc_pkg::IP_PROTO_TCP &&
                   len_x >= 17'(thr) + 17'(ehc_pkg::TCP_HDR_BYTES)) begin
        cls = ehc_pkg::CLS_TCP;
      end else if (pt_nxt[15:8] == ehc_pkg::IP_PROTO_UDP &&
                   len_x >= 17'(thr) + 17'(ehc_pkg::UDP_HDR_LEN)) begin
        cls = ehc_pkg::CLS_UDP;
      end
    end
  end

  assign q_push = acc && in_data.last_byte && en_r && (len >= ehc_pkg::ETH_HDR_LEN);

  always_comb begin
    q_rec.cls        = cls;
    q_rec.type_field = type_nxt;
    q_rec.proto_ttl  = pt_nxt;
    q_rec.arp_op     = aop_nxt;
    q_rec.ip_src     = isrc_nxt;
    q_rec.ip_dst     = idst_nxt;
    q_rec.arp_src    = asrc_nxt;
    q_rec.arp_dst    = adst_nxt;
    q_rec.l4_head    = l4h_nxt;
    q_rec.l4_flags   = l4f_nxt;
    q_rec.frame_len  = len;
    q_rec.pkt_num    = pkt_r + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b1;
      idx_r  <= '0;
      pkt_r  <= '0;
      type_r <= '0;
      hlw_r  <= '0;
      pt_r   <= '0;
      aop_r  <= '0;
      isrc_r <= '0;
      idst_r <= '0;
      asrc_r <= '0;
      adst_r <= '0;
      l4h_r  <= '0;
      l4f_r  <= '0;
    end else begin
      if (cfg_we) begin
        en_r <= cfg_wdata;
      end
      if (acc) begin
        if (in_data.last_byte) begin
          if (en_r) begin
            pkt_r <= pkt_r + 32'd1;
          end
          idx_r  <= '0;
          type_r <= '0;
          hlw_r  <= '0;
          pt_r   <= '0;
          aop_r  <= '0;
          isrc_r <= '0;
          idst_r <= '0;
          asrc_r <= '0;
          adst_r <= '0;
          l4h_r  <= '0;
          l4f_r  <= '0;
        end else begin
          idx_r  <= len;
          type_r <= type_nxt;
          hlw_r  <= hlw_nxt;
          pt_r   <= pt_nxt;
          aop_r  <= aop_nxt;
          isrc_r <= isrc_nxt;
          idst_r <= idst_nxt;
          asrc_r <= asrc_nxt;
          adst_r <= adst_nxt;
          l4h_r  <= l4h_nxt;
          l4f_r  <= l4f_nxt;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ehc_queue.sv -----
// ----------------------------------------------------------------------------
// Header classifier record queue
// Small FIFO of classified records between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ethernet_ip_header_classifier_core_assert.svh"

module ehc_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire ehc_pkg::ehc_rec_t wr_rec,
  output logic                   full,
  input  wire logic              pop,
  output ehc_pkg::ehc_rec_t      rd_rec,
  output logic                   empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ehc_pkg::ehc_rec_t slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;

  assign full   = (cnt_r == CNT_W'(DEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_rec = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  `EHC_ASSERT_NEVER(a_no_overflow, clk, rst_n, push && full)
  `EHC_ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && empty)
  `EHC_ASSERT(a_count_range, clk, rst_n, cnt_r <= CNT_W'(DEPTH))

endmodule

`default_nettype wire

// ----- hw/rtl/ehc_back.sv -----
// ----------------------------------------------------------------------------
// Header classifier back end
// Selects the result fields for each record's class and holds the output.
// ----------------------------------------------------------------------------
`default_nettype none

module ehc_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire ehc_pkg::ehc_rec_t q_rec,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ehc_pkg::ehc_out_t      out_data
);

  logic              out_valid_r;
  ehc_pkg::ehc_out_t out_data_r;
  ehc_pkg::ehc_out_t res_nxt;
  logic              load;

  assign load      = !out_valid_r || !out_stall;
  assign q_pop     = load && !q_empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    res_nxt                = '0;
    res_nxt.protocol_class = q_rec.cls;
    res_nxt.type_field     = q_rec.type_field;
    res_nxt.frame_length   = q_rec.frame_len;
    res_nxt.packet_number  = q_rec.pkt_num;
    case (q_rec.cls)
      ehc_pkg::CLS_OTHER: begin
      end
      ehc_pkg::CLS_ARP: begin
        res_nxt.source_address  = q_rec.arp_src;
        res_nxt.target_address  = q_rec.arp_dst;
        res_nxt.op_or_type_code = q_rec.arp_op;
      end
      ehc_pkg::CLS_IPV4, ehc_pkg::CLS_ICMP, ehc_pkg::CLS_TCP, ehc_pkg::CLS_UDP: begin
        res_nxt.source_address = q_rec.ip_src;
        res_nxt.target_address = q_rec.ip_dst;
        res_nxt.ip_proto       = q_rec.proto_ttl[15:8];
        res_nxt.time_to_live   = q_rec.proto_ttl[7:0];
        if (q_rec.cls == ehc_pkg::CLS_ICMP) begin
          res_nxt.op_or_type_code = q_rec.l4_head[31:16];
        end
        if (q_rec.cls == ehc_pkg::CLS_TCP || q_rec.cls == ehc_pkg::CLS_UDP) begin
          res_nxt.source_port = q_rec.l4_head[31:16];
          res_nxt.dest_port   = q_rec.l4_head[15:0];
        end
        if (q_rec.cls == ehc_pkg::CLS_TCP) begin
          res_nxt.tcp_flag_bits = q_rec.l4_flags;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- verif/ethernet_ip_header_classifier_core_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ethernet/IP header classifier result checker
// Watches the byte, result and configuration ports, tracks the frame parse
// state of the core and compares every result transaction with the record
// that the parse predicts, field by field and in order.
// ----------------------------------------------------------------------------
`default_nettype none

module ethernet_ip_header_classifier_core_checker (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire ehc_pkg::ehc_in_t  in_data,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire ehc_pkg::ehc_out_t out_data,
  output int                     fail_count,
  output int                     records_pending
);

  logic        capture_on;
  logic [15:0] byte_pos;
  logic [31:0] frame_count;
  logic [15:0] eth_type;
  logic [3:0]  ihl_words;
  logic [7:0]  ip_protocol;
  logic [7:0]  ip_ttl;
  logic [15:0] arp_opcode;
  logic [31:0] ip_src;
  logic [31:0] ip_dst;
  logic [31:0] arp_sender;
  logic [31:0] arp_target;
  logic [31:0] l4_word;
  logic [7:0]  l4_flags;

  ehc_pkg::ehc_out_t expected_records[$];
  ehc_pkg::ehc_out_t want;
  int                mismatches = 0;

  assign fail_count = mismatches;

  task automatic clear_frame();
    byte_pos    = '0;
    eth_type    = '0;
    ihl_words   = '0;
    ip_protocol = '0;
    ip_ttl      = '0;
    arp_opcode  = '0;
    ip_src      = '0;
    ip_dst      = '0;
    arp_sender  = '0;
    arp_target  = '0;
    l4_word     = '0;
    l4_flags    = '0;
  endtask

  task automatic emit_record();
    ehc_pkg::ehc_out_t rec;
    int                tlen;
    rec = '0;
    rec.type_field    = eth_type;
    rec.frame_length  = byte_pos;
    rec.packet_number = frame_count;
    if (eth_type == ehc_pkg::TYPE_ARP && byte_pos >= ehc_pkg::ARP_MIN_LEN) begin
      rec.protocol_class  = ehc_pkg::CLS_ARP;
      rec.source_address  = arp_sender;
      rec.target_address  = arp_target;
      rec.op_or_type_code = arp_opcode;
    end else if (eth_type == ehc_pkg::TYPE_IPV4 && byte_pos >= ehc_pkg::IPV4_MIN_LEN) begin
      tlen = int'(byte_pos) - int'(ehc_pkg::ETH_HDR_LEN) - 4 * int'(ihl_words);
      rec.protocol_class = ehc_pkg::CLS_IPV4;
      rec.source_address = ip_src;
      rec.target_address = ip_dst;
      rec.ip_proto       = ip_protocol;
      rec.time_to_live   = ip_ttl;
      if (ip_protocol == ehc_pkg::IP_PROTO_ICMP &&
          tlen >= int'(ehc_pkg::ICMP_HDR_LEN)) begin
        rec.protocol_class  = ehc_pkg::CLS_ICMP;
        rec.op_or_type_code = l4_word[31:16];
      end else if (ip_protocol == ehc_pkg::IP_PROTO_TCP &&
                   tlen >= int'(ehc_pkg::TCP_HDR_BYTES)) begin
        rec.protocol_class = ehc_pkg::CLS_TCP;
        rec.source_port    = l4_word[31:16];
        rec.dest_port      = l4_word[15:0];
        rec.tcp_flag_bits  = l4_flags;
      end else if (ip_protocol == ehc_pkg::IP_PROTO_UDP &&
                   tlen >= int'(ehc_pkg::UDP_HDR_LEN)) begin
        rec.protocol_class = ehc_pkg::CLS_UDP;
        rec.source_port    = l4_word[31:16];
        rec.dest_port      = l4_word[15:0];
      end
    end
    expected_records.insert(expected_records.size(), rec);
  endtask

  task automatic classify_byte(input ehc_pkg::ehc_in_t item);
    logic [7:0] b;
    int         pos;
    int         p;
    int         t0;
    b   = item.data_byte;
    pos = int'(byte_pos);
    if (pos == 12 || pos == 13) eth_type = {eth_type[7:0], b};
    if (pos >= int'(ehc_pkg::ETH_HDR_LEN)) begin
      p = pos - int'(ehc_pkg::ETH_HDR_LEN);
      if (p == 0) ihl_words = b[3:0];
      if (p == 8) ip_ttl = b;
      if (p == 9) ip_protocol = b;
      if (p >= 12 && p <= 15) ip_src = {ip_src[23:0], b};
      if (p >= 16 && p <= 19) ip_dst = {ip_dst[23:0], b};
      if (p == 6 || p == 7) arp_opcode = {arp_opcode[7:0], b};
      if (p >= 14 && p <= 17) arp_sender = {arp_sender[23:0], b};
      if (p >= 24 && p <= 27) arp_target = {arp_target[23:0], b};
      t0 = int'(ehc_pkg::ETH_HDR_LEN) + 4 * int'(ihl_words);
      if (pos >= t0) begin
        if (pos - t0 <= 3) l4_word = {l4_word[23:0], b};
        if (pos - t0 == 13) l4_flags = b;
      end
    end
    if (byte_pos != 16'hFFFF) byte_pos = byte_pos + 16'd1;
    if (item.last_byte) begin
      if (capture_on) begin
        frame_count = frame_count + 32'd1;
        if (byte_pos >= ehc_pkg::ETH_HDR_LEN) emit_record();
      end
      clear_frame();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      capture_on  = 1'b1;
      frame_count = '0;
      clear_frame();
      expected_records.delete();
    end else begin
      if (cfg_we) capture_on = cfg_wdata;
      if (in_valid && !in_stall) classify_byte(in_data);
      if (out_valid && !out_stall) begin
        if (expected_records.size() == 0) begin
          $display("%0t: unexpected result transaction: expected none, actual %h",
                   $time, out_data);
          mismatches++;
        end else begin
          want = expected_records.pop_front();
          check_field("protocol_class", want.protocol_class, out_data.protocol_class);
          check_field("type_field", want.type_field, out_data.type_field);
          check_field("source_address", want.source_address, out_data.source_address);
          check_field("target_address", want.target_address, out_data.target_address);
          check_field("ip_proto", want.ip_proto, out_data.ip_proto);
          check_field("time_to_live", want.time_to_live, out_data.time_to_live);
          check_field("source_port", want.source_port, out_data.source_port);
          check_field("dest_port", want.dest_port, out_data.dest_port);
          check_field("tcp_flag_bits", want.tcp_flag_bits, out_data.tcp_flag_bits);
          check_field("op_or_type_code", want.op_or_type_code, out_data.op_or_type_code);
          check_field("frame_length", want.frame_length, out_data.frame_length);
          check_field("packet_number", want.packet_number, out_data.packet_number);
        end
      end
    end
    records_pending <= expected_records.size();
  end

endmodule

`default_nettype wire

// ----- verif/ethernet_ip_header_classifier_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ethernet/IP header classifier testbench
// Streams directed and random Ethernet frames (runts, ARP, IPv4 with ICMP,
// TCP, UDP and other protocols, short headers and odd IHL values) through
// the core under several sender and receiver idling phases, toggles
// capture, and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
`default_nettype none

module ethernet_ip_header_classifier_core_tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PHASE_BYTES    = 90;

  typedef enum int {FRAME_RUNT, FRAME_ARP, FRAME_IPV4, FRAME_OTHER} frame_kind_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;
  logic              in_valid = 1'b0;
  ehc_pkg::ehc_in_t  in_data = '0;
  logic              out_stall = 1'b0;
  logic              in_stall;
  logic              out_valid;
  ehc_pkg::ehc_out_t out_data;

  int fail_count;
  int records_pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int quiet_cycles = 0;

  logic [7:0] frame_buf[$];

  always #5 clk = ~clk;

  ethernet_ip_header_classifier_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  ethernet_ip_header_classifier_core_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .records_pending(records_pending)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("ethernet_ip_header_classifier_core_tb failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    ehc_pkg::ehc_in_t item;
    item.data_byte = b;
    item.last_byte = last;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) begin
      push_byte(frame_buf[i], i == frame_buf.size() - 1);
    end
  endtask

  task automatic make_frame(input frame_kind_t kind, input int len,
                            input logic [7:0] proto, input logic [3:0] ihl);
    frame_buf.delete();
    repeat (len) frame_buf.insert(frame_buf.size(), 8'($urandom_range(255)));
    if (kind == FRAME_ARP && len > 13) begin
      frame_buf[12] = ehc_pkg::TYPE_ARP[15:8];
      frame_buf[13] = ehc_pkg::TYPE_ARP[7:0];
    end
    if (kind == FRAME_IPV4 && len > 13) begin
      frame_buf[12] = ehc_pkg::TYPE_IPV4[15:8];
      frame_buf[13] = ehc_pkg::TYPE_IPV4[7:0];
      if (len > 14) frame_buf[14] = {frame_buf[14][7:4], ihl};
      if (len > 23) frame_buf[23] = proto;
    end
  endtask

  function automatic int l4_header_len(input logic [7:0] proto);
    if (proto == ehc_pkg::IP_PROTO_TCP) return int'(ehc_pkg::TCP_HDR_BYTES);
    if (proto == ehc_pkg::IP_PROTO_ICMP) return int'(ehc_pkg::ICMP_HDR_LEN);
    if (proto == ehc_pkg::IP_PROTO_UDP) return int'(ehc_pkg::UDP_HDR_LEN);
    return 0;
  endfunction

  task automatic send_random_frame();
    int         pick;
    int         r;
    int         len;
    logic [7:0] proto;
    logic [3:0] ihl;
    pick = $urandom_range(99);
    if (pick < 8) begin
      make_frame(FRAME_RUNT, $urandom_range(1, 13), '0, '0);
    end else if (pick < 20) begin
      make_frame(FRAME_OTHER, $urandom_range(14, 64), '0, '0);
    end else if (pick < 40) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(14, 41) : $urandom_range(42, 64);
      make_frame(FRAME_ARP, len, '0, '0);
    end else begin
      r = $urandom_range(99);
      if (r < 28) proto = ehc_pkg::IP_PROTO_ICMP;
      else if (r < 56) proto = ehc_pkg::IP_PROTO_TCP;
      else if (r < 84) proto = ehc_pkg::IP_PROTO_UDP;
      else proto = 8'($urandom_range(255));
      ihl = ($urandom_range(9) < 7) ? 4'd5 : 4'($urandom_range(15));
      if ($urandom_range(9) == 0) begin
        len = $urandom_range(14, 40);
      end else begin
        len = int'(ehc_pkg::ETH_HDR_LEN) + 4 * int'(ihl) + l4_header_len(proto);
        if (len < int'(ehc_pkg::IPV4_MIN_LEN)) len = int'(ehc_pkg::IPV4_MIN_LEN);
        len = len - 3 + $urandom_range(12);
      end
      make_frame(FRAME_IPV4, len, proto, ihl);
    end
    send_frame();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (records_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capture(input logic value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic capture_off_burst();
    drain();
    write_capture(1'b0);
    repeat (2) send_random_frame();
    make_frame(FRAME_RUNT, 1, '0, '0);
    send_frame();
    drain();
    write_capture(1'b1);
  endtask

  initial begin
    int first_byte;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_capture(1'b1);

    make_frame(FRAME_RUNT, 1, '0, '0);
    frame_buf[0] = 8'hFF;
    send_frame();
    make_frame(FRAME_RUNT, 13, '0, '0);
    send_frame();
    frame_buf.delete();
    repeat (14) frame_buf.insert(frame_buf.size(), 8'h00);
    send_frame();
    frame_buf.delete();
    repeat (60) frame_buf.insert(frame_buf.size(), 8'hFF);
    send_frame();
    make_frame(FRAME_ARP, int'(ehc_pkg::ARP_MIN_LEN), '0, '0);
    send_frame();
    make_frame(FRAME_ARP, int'(ehc_pkg::ARP_MIN_LEN) - 1, '0, '0);
    send_frame();
    make_frame(FRAME_IPV4, int'(ehc_pkg::IPV4_MIN_LEN) - 1, ehc_pkg::IP_PROTO_TCP, 4'd5);
    send_frame();
    make_frame(FRAME_IPV4, int'(ehc_pkg::IPV4_MIN_LEN), 8'hFF, 4'd5);
    send_frame();
    make_frame(FRAME_IPV4, 42, ehc_pkg::IP_PROTO_ICMP, 4'd5);
    send_frame();
    make_frame(FRAME_IPV4, 41, ehc_pkg::IP_PROTO_ICMP, 4'd5);
    send_frame();
    make_frame(FRAME_IPV4, 54, ehc_pkg::IP_PROTO_TCP, 4'd5);
    send_frame();
    make_frame(FRAME_IPV4, 53, ehc_pkg::IP_PROTO_TCP, 4'd5);
    send_frame();
    make_frame(FRAME_IPV4, 42, ehc_pkg::IP_PROTO_UDP, 4'd5);
    send_frame();
    make_frame(FRAME_IPV4, 41, ehc_pkg::IP_PROTO_UDP, 4'd5);
    send_frame();
    make_frame(FRAME_IPV4, 40, ehc_pkg::IP_PROTO_TCP, 4'd0);
    send_frame();
    make_frame(FRAME_IPV4, 38, ehc_pkg::IP_PROTO_ICMP, 4'd3);
    send_frame();
    make_frame(FRAME_IPV4, 82, ehc_pkg::IP_PROTO_UDP, 4'd15);
    send_frame();

    capture_off_burst();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 81;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 81;
        end
        default: begin
          idle_pct  = 36;
          stall_pct = 36;
        end
      endcase
      first_byte = bytes_sent;
      while (bytes_sent - first_byte < PHASE_BYTES) begin
        send_random_frame();
      end
      if (phase == 2) capture_off_burst();
    end

    drain();
    if (fail_count == 0 && records_pending == 0) begin
      $display("ethernet_ip_header_classifier_core_tb passed");
    end else begin
      $display("ethernet_ip_header_classifier_core_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- ethernet_ip_header_classifier_core.f -----
+incdir+hw/rtl
hw/rtl/ehc_pkg.sv
hw/rtl/ehc_front.sv
hw/rtl/ehc_queue.sv
hw/rtl/ehc_back.sv
hw/rtl/ethernet_ip_header_classifier_core.sv
verif/ethernet_ip_header_classifier_core_checker.sv
verif/ethernet_ip_header_classifier_core_tb.sv
